FILE: rtl/jrds_pkg.sv
// Shared constants, types and the exponent root table for the stick shaper.
// No dependencies; every other file in rtl/ imports this package.
package jrds_pkg;

	// Register index codes (byte address / 4)
	localparam logic [2:0] REG_DEADZONE = 3'd0;
	localparam logic [2:0] REG_EXPONENT = 3'd1;
	localparam logic [2:0] REG_INV_X    = 3'd2;
	localparam logic [2:0] REG_INV_Y    = 3'd3;
	localparam logic [2:0] REG_DPU      = 3'd4;

	// Datapath widths
	localparam int RAD_W   = 32;  // sum of squares
	localparam int LOG_W   = 15;  // remapped magnitude fed to the log unit
	localparam int FRAC_W  = 16;  // log / exp fraction bits
	localparam int MANT_W  = 31;  // Q1.30 mantissa
	localparam int Q_SHIFT = 30;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [15:0]       mag_t;

	// Root c_j of the exp table: c_0 = 2^29, c_j = floor(sqrt(c_(j-1) * 2^30))
	function automatic logic [29:0] exp_root(input int j);
		longint unsigned c;
		longint unsigned v;
		longint unsigned res;
		longint unsigned bt;
		c = 64'd1 << 29;
		for (int i = 0; i < j; i++) begin
			v = c << 30;
			res = 0;
			bt = 64'd1 << 62;
			for (int b = 0; b < 32; b++) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			c = res;
		end
		return c[29:0];
	endfunction

endpackage

FILE: rtl/jrds_isqrt.sv
// Pipelined digit-by-digit integer square root, four result bits per stage.
// Depends on jrds_pkg for the radicand width.
module jrds_isqrt #(
	parameter int SW = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             v_in,
	input  logic [jrds_pkg::RAD_W-1:0]       rad_in,
	input  logic [SW-1:0]                    side_in,
	output logic                             v_out,
	output logic [jrds_pkg::RAD_W/2-1:0]     root_out,
	output logic [SW-1:0]                    side_out
);
	import jrds_pkg::*;

	localparam int ITER  = RAD_W / 2;
	localparam int STEPS = 4;
	localparam int NST   = (ITER + STEPS - 1) / STEPS;
	localparam int REM_W = ITER + 4;

	logic             vld_s  [NST];
	logic [RAD_W-1:0] rad_s  [NST];
	logic [ITER-1:0]  root_s [NST];
	logic [REM_W-1:0] rem_s  [NST];
	logic [SW-1:0]    side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic             vld_i;
		logic [RAD_W-1:0] rad_i;
		logic [ITER-1:0]  root_i;
		logic [REM_W-1:0] rem_i;
		logic [SW-1:0]    side_i;
		logic [RAD_W-1:0] rad_n;
		logic [ITER-1:0]  root_n;
		logic [REM_W-1:0] rem_n;

		if (g == 0) begin : g_first
			assign vld_i  = v_in;
			assign rad_i  = rad_in;
			assign root_i = '0;
			assign rem_i  = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i  = vld_s[g-1];
			assign rad_i  = rad_s[g-1];
			assign root_i = root_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign side_i = side_s[g-1];
		end

		// Bring down two radicand bits, try root*4+1, keep the result bit
		always_comb begin
			logic [REM_W-1:0] trial;
			rad_n  = rad_i;
			root_n = root_i;
			rem_n  = rem_i;
			for (int j = 0; j < STEPS; j++) begin
				if (g * STEPS + j < ITER) begin
					rem_n = {rem_n[REM_W-3:0], rad_n[RAD_W-1 -: 2]};
					rad_n = {rad_n[RAD_W-3:0], 2'b00};
					trial = {2'b00, root_n, 2'b01};
					if (rem_n >= trial) begin
						rem_n  = rem_n - trial;
						root_n = {root_n[ITER-2:0], 1'b1};
					end else begin
						root_n = {root_n[ITER-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= rad_n;
				root_s[g] <= root_n;
				rem_s[g]  <= rem_n;
				side_s[g] <= side_i;
			end
		end
	end

	assign v_out    = vld_s[NST-1];
	assign root_out = root_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

FILE: rtl/jrds_div.sv
// Pipelined restoring divider, several lanes over one shared divisor.
// Imports jrds_pkg but uses none of it; quotient must fit in QW bits.
module jrds_div #(
	parameter int LANES = 1,
	parameter int NW    = 31,
	parameter int DW    = 16,
	parameter int QW    = 16,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  logic [LANES-1:0][NW-1:0]   num_in,
	input  logic [DW-1:0]              den_in,
	input  logic [SW-1:0]              side_in,
	output logic                       v_out,
	output logic [LANES-1:0][QW-1:0]   quo_out,
	output logic [SW-1:0]              side_out
);
	import jrds_pkg::*;

	localparam int STEPS = 4;
	localparam int NST   = (QW + STEPS - 1) / STEPS;
	localparam int HI_W  = NW - QW;

	logic                     vld_s  [NST];
	logic [LANES-1:0][DW:0]   rem_s  [NST];
	logic [LANES-1:0][QW-1:0] low_s  [NST];
	logic [DW-1:0]            den_s  [NST];
	logic [SW-1:0]            side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic                     vld_i;
		logic [LANES-1:0][DW:0]   rem_i;
		logic [LANES-1:0][QW-1:0] low_i;
		logic [DW-1:0]            den_i;
		logic [SW-1:0]            side_i;
		logic [LANES-1:0][DW:0]   rem_n;
		logic [LANES-1:0][QW-1:0] low_n;

		if (g == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_i[l] = {{(DW + 1 - HI_W){1'b0}}, num_in[l][NW-1:QW]};
					low_i[l] = num_in[l][QW-1:0];
				end
			end
			assign vld_i  = v_in;
			assign den_i  = den_in;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i  = vld_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign low_i  = low_s[g-1];
			assign den_i  = den_s[g-1];
			assign side_i = side_s[g-1];
		end

		// Shift in one dividend bit, subtract where it fits, record the bit
		always_comb begin
			rem_n = rem_i;
			low_n = low_i;
			for (int l = 0; l < LANES; l++) begin
				for (int j = 0; j < STEPS; j++) begin
					if (g * STEPS + j < QW) begin
						rem_n[l] = {rem_n[l][DW-1:0], low_n[l][QW-1]};
						low_n[l] = {low_n[l][QW-2:0], 1'b0};
						if (rem_n[l] >= {1'b0, den_i}) begin
							rem_n[l]    = rem_n[l] - {1'b0, den_i};
							low_n[l][0] = 1'b1;
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_n;
				low_s[g]  <= low_n;
				den_s[g]  <= den_i;
				side_s[g] <= side_i;
			end
		end
	end

	assign v_out    = vld_s[NST-1];
	assign quo_out  = low_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

FILE: rtl/jrds_log2.sv
// Pipelined log2: normalize stage, then one mantissa squaring per stage.
// Depends on jrds_pkg for widths and the fraction type.
module jrds_log2 #(
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic [jrds_pkg::LOG_W-1:0]  r_in,
	input  logic [SW-1:0]               side_in,
	output logic                        v_out,
	output logic [3:0]                  n_out,
	output jrds_pkg::frac_t             frac_out,
	output logic [SW-1:0]               side_out
);
	import jrds_pkg::*;

	logic              vld_s  [FRAC_W+1];
	logic [MANT_W-1:0] m_s    [FRAC_W+1];
	frac_t             frac_s [FRAC_W+1];
	logic [3:0]        n_s    [FRAC_W+1];
	logic [SW-1:0]     side_s [FRAC_W+1];

	logic [3:0]        n0;
	logic [MANT_W-1:0] m0;

	// Find the leading one and left-align the mantissa to Q1.30
	always_comb begin
		n0 = '0;
		for (int i = 0; i < LOG_W; i++) begin
			if (r_in[i]) begin
				n0 = 4'(i);
			end
		end
		m0 = MANT_W'(r_in) << (5'd30 - {1'b0, n0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= m0;
			frac_s[0] <= '0;
			n_s[0]    <= n0;
			side_s[0] <= side_in;
		end
	end

	for (genvar g = 0; g < FRAC_W; g++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     t;
		logic [MANT_W-1:0]   m_n;

		// Square, keep Q1.30, renormalize when it reaches two
		always_comb begin
			sq  = m_s[g] * m_s[g];
			t   = sq[Q_SHIFT +: MANT_W+1];
			m_n = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g+1]    <= m_n;
				frac_s[g+1] <= {frac_s[g][FRAC_W-2:0], t[MANT_W]};
				n_s[g+1]    <= n_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign v_out    = vld_s[FRAC_W];
	assign n_out    = n_s[FRAC_W];
	assign frac_out = frac_s[FRAC_W];
	assign side_out = side_s[FRAC_W];

endmodule

FILE: rtl/jrds_exp2.sv
// Pipelined 2^-(k + f): one root-table multiply per stage, then a rounding shift.
// Depends on jrds_pkg for widths and the exp_root table function.
module jrds_exp2 #(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  jrds_pkg::frac_t  f_in,
	input  logic [7:0]       k_in,
	input  logic [SW-1:0]    side_in,
	output logic             v_out,
	output jrds_pkg::mag_t   s_out,
	output logic [SW-1:0]    side_out
);
	import jrds_pkg::*;

	logic              vld_s  [FRAC_W+1];
	logic [MANT_W-1:0] w_s    [FRAC_W];
	frac_t             f_s    [FRAC_W];
	logic [7:0]        k_s    [FRAC_W];
	logic [SW-1:0]     side_s [FRAC_W+1];
	mag_t              s_s;

	for (genvar g = 0; g < FRAC_W; g++) begin : g_mul
		localparam logic [29:0] CJ = exp_root(g + 1);
		logic              vld_i;
		logic [MANT_W-1:0] w_i;
		frac_t             f_i;
		logic [7:0]        k_i;
		logic [SW-1:0]     side_i;
		logic [MANT_W+29:0] prod;
		logic [MANT_W-1:0] w_n;

		if (g == 0) begin : g_first
			assign vld_i  = v_in;
			assign w_i    = MANT_W'(1) << Q_SHIFT;
			assign f_i    = f_in;
			assign k_i    = k_in;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i  = vld_s[g-1];
			assign w_i    = w_s[g-1];
			assign f_i    = f_s[g-1];
			assign k_i    = k_s[g-1];
			assign side_i = side_s[g-1];
		end

		// Multiply in the root for this fraction bit when it is set
		always_comb begin
			prod = w_i * CJ;
			w_n  = f_i[FRAC_W-1-g] ? prod[Q_SHIFT +: MANT_W] : w_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[g]    <= w_n;
				f_s[g]    <= f_i;
				k_s[g]    <= k_i;
				side_s[g] <= side_i;
			end
		end
	end

	// Round w / 2^(15+k); any k of 17 or more gives zero
	logic [4:0]  kc;
	logic [32:0] rsum;
	logic [32:0] rsh;

	always_comb begin
		kc   = (k_s[FRAC_W-1] > 8'd17) ? 5'd17 : k_s[FRAC_W-1][4:0];
		rsum = {2'b00, w_s[FRAC_W-1]} + (33'd1 << (5'd14 + kc));
		rsh  = rsum >> (6'd15 + {1'b0, kc});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[FRAC_W] <= 1'b0;
		end else if (en) begin
			vld_s[FRAC_W] <= vld_s[FRAC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s            <= rsh[15:0];
			side_s[FRAC_W] <= side_s[FRAC_W-1];
		end
	end

	assign v_out    = vld_s[FRAC_W];
	assign s_out    = s_s;
	assign side_out = side_s[FRAC_W];

endmodule

FILE: rtl/joystick_radial_deadzone_shaper_unit.sv
// Top level of the radial deadzone stick shaper: registers, glue stages, output.
// Depends on jrds_pkg, jrds_isqrt, jrds_div, jrds_log2 and jrds_exp2.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, raw_x, raw_y                 | sink
//  out     | out_valid, out_stall, shaped_x/y, shaped_magnitude,
//          | active, look_x, look_y                           | source
//  config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB slave
//
// One stick sample enters per cycle while in_stall is low; each result passes
// through the square root, three dividers, 17 log and 17 exp stages.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipeline, which then holds in_stall high.
module joystick_radial_deadzone_shaper_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  raw_x,
	input  logic signed [15:0]  raw_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  shaped_x,
	output logic signed [16:0]  shaped_y,
	output logic [15:0]         shaped_magnitude,
	output logic                active,
	output logic signed [17:0]  look_x,
	output logic signed [17:0]  look_y
);
	import jrds_pkg::*;

	typedef struct packed {
		mag_t ax;
		mag_t ay;
		logic sx;
		logic sy;
		logic zero;
	} sq_side_t;

	typedef struct packed {
		mag_t ax;
		mag_t ay;
		logic sx;
		logic sy;
		logic zero;
		logic big;
		mag_t mag;
	} nrm_side_t;

	typedef struct packed {
		mag_t ax;
		mag_t ay;
		logic sx;
		logic sy;
		logic zero;
		mag_t mag;
	} rmp_side_t;

	typedef struct packed {
		mag_t ax;
		mag_t ay;
		logic sx;
		logic sy;
		logic zero;
		mag_t mag;
		logic full;
	} pwr_side_t;

	typedef struct packed {
		mag_t s;
		logic sx;
		logic sy;
		logic zero;
	} shp_side_t;

	// ---------------- configuration registers ----------------
	logic [14:0] deadzone_q;
	logic [15:0] exponent_q;
	logic        invert_x_q;
	logic        invert_y_q;
	logic [15:0] dpu_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// Write the addressed register; unknown addresses drop the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= '0;
			exponent_q <= 16'd4096;
			invert_x_q <= 1'b0;
			invert_y_q <= 1'b0;
			dpu_q      <= 16'd256;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_DEADZONE: deadzone_q <= pwdata[14:0];
				REG_EXPONENT: exponent_q <= pwdata[15:0];
				REG_INV_X:    invert_x_q <= pwdata[0];
				REG_INV_Y:    invert_y_q <= pwdata[0];
				REG_DPU:      dpu_q      <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DEADZONE: prdata = {17'd0, deadzone_q};
			REG_EXPONENT: prdata = {16'd0, exponent_q};
			REG_INV_X:    prdata = {31'd0, invert_x_q};
			REG_INV_Y:    prdata = {31'd0, invert_y_q};
			REG_DPU:      prdata = {16'd0, dpu_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// ---------------- s1: canonicalize to sign and magnitude ----------------
	logic     v_s1;
	sq_side_t a_s1;
	mag_t     cx;
	mag_t     cy;

	always_comb begin
		if (raw_x[15]) begin
			cx = 16'(-{raw_x[15], raw_x});
		end else begin
			cx = {1'b0, raw_x[14:0]} + {15'd0, raw_x[14]};
		end
		if (raw_y[15]) begin
			cy = 16'(-{raw_y[15], raw_y});
		end else begin
			cy = {1'b0, raw_y[14:0]} + {15'd0, raw_y[14]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1.ax   <= cx;
			a_s1.ay   <= cy;
			a_s1.sx   <= raw_x[15];
			a_s1.sy   <= !raw_y[15];
			a_s1.zero <= (exponent_q == '0);
		end
	end

	// ---------------- s2: squares ----------------
	logic        v_s2;
	sq_side_t    a_s2;
	logic [30:0] xx_s2;
	logic [30:0] yy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= {15'd0, a_s1.ax} * {15'd0, a_s1.ax};
			yy_s2 <= {15'd0, a_s1.ay} * {15'd0, a_s1.ay};
			a_s2  <= a_s1;
		end
	end

	// ---------------- radial magnitude ----------------
	logic     v_sq;
	mag_t     mag_sq;
	sq_side_t a_sq;

	jrds_isqrt #(.SW($bits(sq_side_t))) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s2),
		.rad_in   ({1'b0, xx_s2} + {1'b0, yy_s2}),
		.side_in  (a_s2),
		.v_out    (v_sq),
		.root_out (mag_sq),
		.side_out (a_sq)
	);

	// ---------------- s3: set up unit-circle renormalization ----------------
	logic                v_s3;
	nrm_side_t           b_s3;
	logic [1:0][30:0]    nnum_s3;
	mag_t                nden_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nnum_s3[0] <= {a_sq.ax, 15'd0} + {16'd0, mag_sq[15:1]};
			nnum_s3[1] <= {a_sq.ay, 15'd0} + {16'd0, mag_sq[15:1]};
			nden_s3    <= (mag_sq == '0) ? 16'd1 : mag_sq;
			b_s3.ax    <= a_sq.ax;
			b_s3.ay    <= a_sq.ay;
			b_s3.sx    <= a_sq.sx;
			b_s3.sy    <= a_sq.sy;
			b_s3.zero  <= a_sq.zero;
			b_s3.big   <= (mag_sq > 16'd32768);
			b_s3.mag   <= mag_sq;
		end
	end

	logic            v_nd;
	logic [1:0][15:0] nq;
	nrm_side_t       b_nd;

	jrds_div #(.LANES(2), .NW(31), .DW(16), .QW(16), .SW($bits(nrm_side_t))) u_div_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s3),
		.num_in   (nnum_s3),
		.den_in   (nden_s3),
		.side_in  (b_s3),
		.v_out    (v_nd),
		.quo_out  (nq),
		.side_out (b_nd)
	);

	// ---------------- s4: deadzone test and remap setup ----------------
	logic            v_s4;
	rmp_side_t       c_s4;
	logic [0:0][30:0] rnum_s4;
	mag_t            rden_s4;
	mag_t            magn;
	logic            in_dz;

	always_comb begin
		magn  = b_nd.big ? 16'd32768 : b_nd.mag;
		in_dz = (magn <= {1'b0, deadzone_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_nd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnum_s4[0] <= in_dz ? '0 : {magn - {1'b0, deadzone_q}, 15'd0};
			rden_s4    <= 16'd32768 - {1'b0, deadzone_q};
			c_s4.ax    <= b_nd.big ? nq[0] : b_nd.ax;
			c_s4.ay    <= b_nd.big ? nq[1] : b_nd.ay;
			c_s4.sx    <= b_nd.sx;
			c_s4.sy    <= b_nd.sy;
			c_s4.zero  <= b_nd.zero || in_dz;
			c_s4.mag   <= magn;
		end
	end

	logic             v_rd;
	logic [0:0][15:0] rq;
	rmp_side_t        c_rd;
	pwr_side_t        d_rd;

	jrds_div #(.LANES(1), .NW(31), .DW(16), .QW(16), .SW($bits(rmp_side_t))) u_div_remap (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s4),
		.num_in   (rnum_s4),
		.den_in   (rden_s4),
		.side_in  (c_s4),
		.v_out    (v_rd),
		.quo_out  (rq),
		.side_out (c_rd)
	);

	always_comb begin
		d_rd.ax   = c_rd.ax;
		d_rd.ay   = c_rd.ay;
		d_rd.sx   = c_rd.sx;
		d_rd.sy   = c_rd.sy;
		d_rd.zero = c_rd.zero;
		d_rd.mag  = c_rd.mag;
		d_rd.full = rq[0][15];
	end

	// ---------------- power curve: log2, scale, exp2 ----------------
	logic      v_lg;
	logic [3:0] n_lg;
	frac_t     frac_lg;
	pwr_side_t d_lg;

	jrds_log2 #(.SW($bits(pwr_side_t))) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_rd),
		.r_in     (rq[0][LOG_W-1:0]),
		.side_in  (d_rd),
		.v_out    (v_lg),
		.n_out    (n_lg),
		.frac_out (frac_lg),
		.side_out (d_lg)
	);

	logic      v_s5;
	pwr_side_t d_s5;
	frac_t     f_s5;
	logic [7:0] k_s5;
	logic [19:0] nlog;
	logic [35:0] psum;

	// Negated log in Q.16, times the Q4.12 exponent, rounded back to Q.16
	always_comb begin
		nlog = {4'd15 - n_lg, 16'd0} - {4'd0, frac_lg};
		psum = (exponent_q * nlog) + 36'd2048;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_lg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5 <= psum[27:12];
			k_s5 <= psum[35:28];
			d_s5 <= d_lg;
		end
	end

	logic      v_ex;
	mag_t      s_ex;
	pwr_side_t d_ex;

	jrds_exp2 #(.SW($bits(pwr_side_t))) u_exp2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s5),
		.f_in     (f_s5),
		.k_in     (k_s5),
		.side_in  (d_s5),
		.v_out    (v_ex),
		.s_out    (s_ex),
		.side_out (d_ex)
	);

	// ---------------- s6: rescale direction setup ----------------
	logic             v_s6;
	shp_side_t        e_s6;
	logic [1:0][30:0] snum_s6;
	mag_t             sden_s6;
	mag_t             sfin;

	assign sfin = d_ex.full ? 16'd32768 : s_ex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_ex;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snum_s6[0] <= {15'd0, d_ex.ax} * {15'd0, sfin} + {16'd0, d_ex.mag[15:1]};
			snum_s6[1] <= {15'd0, d_ex.ay} * {15'd0, sfin} + {16'd0, d_ex.mag[15:1]};
			sden_s6    <= (d_ex.mag == '0) ? 16'd1 : d_ex.mag;
			e_s6.s     <= sfin;
			e_s6.sx    <= d_ex.sx;
			e_s6.sy    <= d_ex.sy;
			e_s6.zero  <= d_ex.zero || (sfin == '0);
		end
	end

	logic             v_sd;
	logic [1:0][15:0] sq_q;
	shp_side_t        e_sd;

	jrds_div #(.LANES(2), .NW(31), .DW(16), .QW(16), .SW($bits(shp_side_t))) u_div_shape (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s6),
		.num_in   (snum_s6),
		.den_in   (sden_s6),
		.side_in  (e_s6),
		.v_out    (v_sd),
		.quo_out  (sq_q),
		.side_out (e_sd)
	);

	// ---------------- s7: signs, look gain, output register ----------------
	logic        negx;
	logic        negy;
	logic [32:0] lxs;
	logic [32:0] lys;
	logic [16:0] ux;
	logic [16:0] uy;
	logic [17:0] ulx;
	logic [17:0] uly;

	always_comb begin
		negx = e_sd.sx ^ invert_x_q;
		negy = e_sd.sy ^ invert_y_q;
		lxs  = {17'd0, sq_q[0]} * {17'd0, dpu_q} + 33'd16384;
		lys  = {17'd0, sq_q[1]} * {17'd0, dpu_q} + 33'd16384;
		ux   = {1'b0, sq_q[0]};
		uy   = {1'b0, sq_q[1]};
		ulx  = lxs[32:15];
		uly  = lys[32:15];
	end

	logic signed [16:0] shaped_x_q;
	logic signed [16:0] shaped_y_q;
	logic [15:0]        shaped_mag_q;
	logic               active_q;
	logic signed [17:0] look_x_q;
	logic signed [17:0] look_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (e_sd.zero) begin
				shaped_x_q   <= '0;
				shaped_y_q   <= '0;
				shaped_mag_q <= '0;
				active_q     <= 1'b0;
				look_x_q     <= '0;
				look_y_q     <= '0;
			end else begin
				shaped_x_q   <= negx ? (~ux + 17'd1) : ux;
				shaped_y_q   <= negy ? (~uy + 17'd1) : uy;
				shaped_mag_q <= e_sd.s;
				active_q     <= 1'b1;
				look_x_q     <= negx ? (~ulx + 18'd1) : ulx;
				look_y_q     <= negy ? (~uly + 18'd1) : uly;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign shaped_x         = shaped_x_q;
	assign shaped_y         = shaped_y_q;
	assign shaped_magnitude = shaped_mag_q;
	assign active           = active_q;
	assign look_x           = look_x_q;
	assign look_y           = look_y_q;

	// ---------------- assertions ----------------
	a_active_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (active_q == (shaped_mag_q != '0)))
		else $error("active flag disagrees with shaped magnitude");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !active_q) |-> (shaped_x_q == '0 && shaped_y_q == '0 &&
			look_x_q == '0 && look_y_q == '0))
		else $error("inactive result carries nonzero fields");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (shaped_mag_q <= 16'd32768))
		else $error("shaped magnitude beyond unit");

	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule
